FILE: sv/assert_macros.svh
// Assertion macros used by the RTL of the contact pipeline.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Checks an implication into the next cycle, reset included.
`define ASSERT_NEXT(label, clk, a, b, msg) \
  label: assert property (@(posedge clk) (a) |=> (b)) else $error(msg);

`endif

FILE: sv/sac_pkg.sv
// Package with constants and types of the sphere and box contact pipeline.
`default_nettype none
package sac_pkg;
  localparam int FRAC_BITS = 16;
  localparam logic [63:0] ONE_FX = 64'd1 << FRAC_BITS;
  localparam logic [63:0] EPS_SQ = (64'd1 << (2 * FRAC_BITS)) / 64'd1000000;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int REM_W = 34;
  localparam int NUM_W = 31 + DIV_STEPS + 1;

  typedef enum logic [2:0] {
    FACE_NX, FACE_PX, FACE_NY, FACE_PY, FACE_NZ, FACE_PZ
  } face_t;

  typedef struct packed {
    logic              contact;
    logic              surf;
    logic [2:0]        neg;
    logic [2:0][30:0]  ad;
    logic [30:0]       r;
    face_t             face;
    logic [31:0]       fdepth;
  } carry_t;
endpackage
`default_nettype wire

FILE: sv/sphere_aabb_contact_top.sv
// Throughput: one transaction per cycle unless the output stalls; the 32
// square root steps and the 17 division steps each hold one register stage,
// so nothing iterates. A stall on the output freezes every stage; nothing
// is lost or repeated. Reset (rst, synchronous) clears every valid bit;
// payload is not reset.
`default_nettype none
module sphere_aabb_contact_top
  import sac_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] sphere_x,
  input  wire logic signed [31:0] sphere_y,
  input  wire logic signed [31:0] sphere_z,
  input  wire logic [30:0]        sphere_radius,
  input  wire logic signed [31:0] box_min_x,
  input  wire logic signed [31:0] box_min_y,
  input  wire logic signed [31:0] box_min_z,
  input  wire logic signed [31:0] box_max_x,
  input  wire logic signed [31:0] box_max_y,
  input  wire logic signed [31:0] box_max_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    contact,
  output logic signed [17:0]      normal_x,
  output logic signed [17:0]      normal_y,
  output logic signed [17:0]      normal_z,
  output logic [31:0]             depth
);
`include "assert_macros.svh"

  // The whole pipeline moves together; it only holds when the output
  // register carries a result that the downstream side is not taking.
  logic adv;
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage 1: clamp the center into the box and form per-axis offsets and
  // the six face distances.
  logic signed [31:0] c_in [3];
  logic signed [31:0] lo_in [3];
  logic signed [31:0] hi_in [3];
  logic signed [32:0] d_c [3];
  logic signed [32:0] f_c [6];
  always_comb begin
    c_in[0] = sphere_x;  c_in[1] = sphere_y;  c_in[2] = sphere_z;
    lo_in[0] = box_min_x; lo_in[1] = box_min_y; lo_in[2] = box_min_z;
    hi_in[0] = box_max_x; hi_in[1] = box_max_y; hi_in[2] = box_max_z;
    for (int k = 0; k < 3; k++) begin
      // Below-min wins over above-max, which matters for inverted boxes.
      if (c_in[k] < lo_in[k]) begin
        d_c[k] = 33'(c_in[k]) - 33'(lo_in[k]);
      end else if (c_in[k] > hi_in[k]) begin
        d_c[k] = 33'(c_in[k]) - 33'(hi_in[k]);
      end else begin
        d_c[k] = '0;
      end
      f_c[2 * k]     = 33'(c_in[k]) - 33'(lo_in[k]);
      f_c[2 * k + 1] = 33'(hi_in[k]) - 33'(c_in[k]);
    end
  end

  logic               s1_vld;
  logic [32:0]        s1_ad [3];
  logic [2:0]         s1_neg;
  logic signed [32:0] s1_f [6];
  logic [30:0]        s1_r;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s1_neg[k] <= d_c[k][32];
        s1_ad[k]  <= d_c[k][32] ? 33'(-d_c[k]) : 33'(d_c[k]);
      end
      for (int k = 0; k < 6; k++) begin
        s1_f[k] <= f_c[k];
      end
      s1_r <= sphere_radius;
    end
  end

  // Stage 2: squares of the offsets and of the radius, nearest face.
  // An offset at or above 2^31 exceeds any radius, so it flags no contact
  // and the squares stay 31 by 31 bits.
  face_t              face_c;
  logic signed [32:0] fmin_c;
  always_comb begin
    face_c = FACE_NX;
    fmin_c = s1_f[0];
    for (int k = 1; k < 6; k++) begin
      if (s1_f[k] < fmin_c) begin
        fmin_c = s1_f[k];
        face_c = face_t'(3'(k));
      end
    end
  end

  logic               s2_vld;
  logic [61:0]        s2_sq [3];
  logic [61:0]        s2_rr;
  logic               s2_big;
  face_t              s2_face;
  logic signed [32:0] s2_fmin;
  logic [30:0]        s2_r;
  logic [2:0]         s2_neg;
  logic [2:0][30:0]   s2_ad;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s2_sq[k] <= 62'(s1_ad[k][30:0]) * 62'(s1_ad[k][30:0]);
        s2_ad[k] <= s1_ad[k][30:0];
      end
      s2_big  <= (|s1_ad[0][32:31]) || (|s1_ad[1][32:31]) || (|s1_ad[2][32:31]);
      s2_rr   <= 62'(s1_r) * 62'(s1_r);
      s2_face <= face_c;
      s2_fmin <= fmin_c;
      s2_r    <= s1_r;
      s2_neg  <= s1_neg;
    end
  end

  // Stage 3: squared distance, contact and case decisions, face depth.
  logic [63:0]        dsq_c;
  logic signed [34:0] fsum_c;
  logic [31:0]        fdep_c;
  always_comb begin
    dsq_c  = 64'(s2_sq[0]) + 64'(s2_sq[1]) + 64'(s2_sq[2]);
    fsum_c = 35'(s2_r) + 35'(s2_fmin);
    if (fsum_c < 0) begin
      fdep_c = '0;
    end else if (fsum_c > 35'sh0FFFFFFFF) begin
      fdep_c = '1;
    end else begin
      fdep_c = fsum_c[31:0];
    end
  end

  // Square root pipeline, one result bit per stage; entry 0 is stage 3.
  logic [63:0] sq_v   [0:SQRT_STEPS];
  logic [63:0] sq_res [0:SQRT_STEPS];
  carry_t      sq_c   [0:SQRT_STEPS];
  logic        sq_vld [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (adv) begin
      sq_vld[0] <= s2_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_v[0]           <= dsq_c;
      sq_res[0]         <= '0;
      sq_c[0].contact   <= !s2_big && (dsq_c <= 64'(s2_rr));
      sq_c[0].surf      <= dsq_c > EPS_SQ;
      sq_c[0].neg       <= s2_neg;
      sq_c[0].ad        <= s2_ad;
      sq_c[0].r         <= s2_r;
      sq_c[0].face      <= s2_face;
      sq_c[0].fdepth    <= fdep_c;
    end
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    logic [63:0] step_bit;
    logic [63:0] trial;
    logic        take;
    assign step_bit = 64'd1 << (2 * (SQRT_STEPS - 1 - i));
    assign trial = sq_res[i] + step_bit;
    assign take  = sq_v[i] >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[i + 1] <= 1'b0;
      end else if (adv) begin
        sq_vld[i + 1] <= sq_vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_v[i + 1]   <= take ? sq_v[i] - trial : sq_v[i];
        sq_res[i + 1] <= take ? (sq_res[i] >> 1) + step_bit : sq_res[i] >> 1;
        sq_c[i + 1]   <= sq_c[i];
      end
    end
  end

  // Division pipeline for the surface normal: each component is
  // (ad * 2^(FRAC_BITS+1) + dist) / (2 * dist), which stays at or below one.
  logic [31:0]      dist_c;
  logic [NUM_W-1:0] num_c [3];
  assign dist_c = sq_res[SQRT_STEPS][31:0];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_c[k] = NUM_W'({sq_c[SQRT_STEPS].ad[k], {DIV_STEPS{1'b0}}}) + NUM_W'(dist_c);
    end
  end

  logic [2:0][REM_W-1:0]     dv_rem [0:DIV_STEPS];
  logic [2:0][DIV_STEPS-1:0] dv_q   [0:DIV_STEPS];
  logic [2:0][DIV_STEPS-1:0] dv_low [0:DIV_STEPS];
  logic [32:0]               dv_d   [0:DIV_STEPS];
  logic [31:0]               dv_dist[0:DIV_STEPS];
  carry_t                    dv_c   [0:DIV_STEPS];
  logic                      dv_vld [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (adv) begin
      dv_vld[0] <= sq_vld[SQRT_STEPS];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        dv_rem[0][k] <= REM_W'(num_c[k] >> DIV_STEPS);
        dv_low[0][k] <= num_c[k][DIV_STEPS-1:0];
        dv_q[0][k]   <= '0;
      end
      dv_d[0]    <= {dist_c, 1'b0};
      dv_dist[0] <= dist_c;
      dv_c[0]    <= sq_c[SQRT_STEPS];
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [REM_W-1:0] t [3];
    logic [2:0]       ge;
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        t[k]  = {dv_rem[i][k][REM_W-2:0], dv_low[i][k][DIV_STEPS-1]};
        ge[k] = t[k] >= REM_W'(dv_d[i]);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[i + 1] <= 1'b0;
      end else if (adv) begin
        dv_vld[i + 1] <= dv_vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int k = 0; k < 3; k++) begin
          dv_rem[i + 1][k] <= ge[k] ? t[k] - REM_W'(dv_d[i]) : t[k];
          dv_q[i + 1][k]   <= {dv_q[i][k][DIV_STEPS-2:0], ge[k]};
          dv_low[i + 1][k] <= dv_low[i][k] << 1;
        end
        dv_d[i + 1]    <= dv_d[i];
        dv_dist[i + 1] <= dv_dist[i];
        dv_c[i + 1]    <= dv_c[i];
      end
    end
  end

  // Output stage: pick the surface or the face result; zeros without contact.
  carry_t           fc;
  logic [17:0]      nrm_c [3];
  logic [31:0]      dep_c;
  logic [17:0]      one18;
  logic [DIV_STEPS-1:0] n_k;
  assign fc    = dv_c[DIV_STEPS];
  assign one18 = 18'(ONE_FX);
  always_comb begin
    n_k = '0;
    for (int k = 0; k < 3; k++) begin
      nrm_c[k] = '0;
    end
    dep_c = '0;
    if (fc.contact && fc.surf) begin
      for (int k = 0; k < 3; k++) begin
        n_k = dv_q[DIV_STEPS][k];
        if (64'(n_k) > ONE_FX) begin
          n_k = DIV_STEPS'(ONE_FX);
        end
        nrm_c[k] = fc.neg[k] ? 18'(-18'(n_k)) : 18'(n_k);
      end
      dep_c = 32'(fc.r) - dv_dist[DIV_STEPS];
    end else if (fc.contact) begin
      case (fc.face)
        FACE_NX: nrm_c[0] = -one18;
        FACE_PX: nrm_c[0] = one18;
        FACE_NY: nrm_c[1] = -one18;
        FACE_PY: nrm_c[1] = one18;
        FACE_NZ: nrm_c[2] = -one18;
        FACE_PZ: nrm_c[2] = one18;
        default: nrm_c[0] = '0;
      endcase
      dep_c = fc.fdepth;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_vld[DIV_STEPS];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      contact  <= fc.contact;
      normal_x <= nrm_c[0];
      normal_y <= nrm_c[1];
      normal_z <= nrm_c[2];
      depth    <= dep_c;
    end
  end

  // A result without contact carries an all-zero record.
  `ASSERT_IMPL(a_nocontact_zero, clk, rst, out_valid && !contact,
    normal_x == 18'sd0 && normal_y == 18'sd0 && normal_z == 18'sd0 && depth == 32'd0,
    "no-contact result with nonzero fields")
  // Output register holds while the downstream side stalls it.
  `ASSERT_IMPL(a_hold_on_stall, clk, rst, out_valid && out_stall,
    in_stall, "pipeline advanced into a stalled output")
  // Reset empties the output stage.
  `ASSERT_NEXT(a_reset_clears, clk, rst, !out_valid, "output valid after reset")
endmodule
`default_nettype wire

FILE: sim/sphere_aabb_contact_top_tb.sv
// Self-checking testbench for the sphere and box contact pipeline.
`default_nettype none
module sphere_aabb_contact_top_tb;
  import sac_pkg::*;

  // One sphere and box pair as it is offered on the input side.
  typedef struct {
    int         cx, cy, cz;
    bit [30:0]  radius;
    int         lox, loy, loz;
    int         hix, hiy, hiz;
  } pair_t;

  // One contact record as it leaves the block.
  typedef struct {
    bit                contact;
    logic signed [17:0] nx, ny, nz;
    bit [31:0]         depth;
  } contact_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] sphere_x = '0, sphere_y = '0, sphere_z = '0;
  logic [30:0] sphere_radius = '0;
  logic signed [31:0] box_min_x = '0, box_min_y = '0, box_min_z = '0;
  logic signed [31:0] box_max_x = '0, box_max_y = '0, box_max_z = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic contact;
  logic signed [17:0] normal_x, normal_y, normal_z;
  logic [31:0] depth;

  sphere_aabb_contact_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sphere_x(sphere_x), .sphere_y(sphere_y), .sphere_z(sphere_z),
    .sphere_radius(sphere_radius),
    .box_min_x(box_min_x), .box_min_y(box_min_y), .box_min_z(box_min_z),
    .box_max_x(box_max_x), .box_max_y(box_max_y), .box_max_z(box_max_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .contact(contact), .normal_x(normal_x), .normal_y(normal_y),
    .normal_z(normal_z), .depth(depth)
  );

  always #1 clk = ~clk;

  // The block is 54 stages deep; drains wait a little longer than that.
  localparam int PIPE_DEPTH = 54;
  localparam int WATCHDOG_LIMIT = 5000;

  contact_t contacts_due[$];
  int  fail_count = 0;
  int  tx_idle_pct = 28;
  int  rx_idle_pct = 28;
  int  rx_hold_cycles = 0;
  int  quiet_cycles = 0;

  // Integer square root, floor, by the bit-pair method.
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bitpos;
    res = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > v) bitpos >>= 2;
    while (bitpos != 0) begin
      if (v >= res + bitpos) begin
        v -= res + bitpos;
        res = (res >> 1) + bitpos;
      end else begin
        res >>= 1;
      end
      bitpos >>= 2;
    end
    return res;
  endfunction

  // Computes the contact record that the block must produce for one pair.
  function automatic contact_t predict_contact(pair_t p);
    longint c[3], lo[3], hi[3], pt, d, f[6], dep;
    longint unsigned ad[3], sq, dsq, r, span, n;
    bit neg[3];
    logic [17:0] fld;
    face_t best;
    contact_t e;
    c = '{p.cx, p.cy, p.cz};
    lo = '{p.lox, p.loy, p.loz};
    hi = '{p.hix, p.hiy, p.hiz};
    r = p.radius;
    dsq = 0;
    for (int k = 0; k < 3; k++) begin
      // Below-min is tested first, which matters for an inverted box.
      pt = c[k] < lo[k] ? lo[k] : (c[k] > hi[k] ? hi[k] : c[k]);
      d = c[k] - pt;
      neg[k] = d < 0;
      ad[k] = neg[k] ? longint'(-d) : longint'(d);
      sq = ad[k] * ad[k];
      dsq = (dsq > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : dsq + sq;
    end
    e = '{contact: 1'b0, nx: '0, ny: '0, nz: '0, depth: '0};
    if (dsq > r * r) return e;
    e.contact = 1'b1;
    if (dsq > EPS_SQ) begin
      span = floor_sqrt(dsq);
      for (int k = 0; k < 3; k++) begin
        n = ((ad[k] << FRAC_BITS) * 2 + span) / (2 * span);
        if (n > ONE_FX) n = ONE_FX;
        fld = neg[k] ? 18'(0 - n) : 18'(n);
        if (k == 0) e.nx = fld;
        else if (k == 1) e.ny = fld;
        else e.nz = fld;
      end
      e.depth = 32'(r - span);
    end else begin
      for (int k = 0; k < 3; k++) begin
        f[2 * k] = c[k] - lo[k];
        f[2 * k + 1] = hi[k] - c[k];
      end
      best = FACE_NX;
      for (int k = 1; k < 6; k++)
        if (f[k] < f[best]) best = face_t'(k);
      fld = (best inside {FACE_NX, FACE_NY, FACE_NZ}) ? 18'(0 - ONE_FX) : 18'(ONE_FX);
      case (best)
        FACE_NX, FACE_PX: e.nx = fld;
        FACE_NY, FACE_PY: e.ny = fld;
        default: e.nz = fld;
      endcase
      dep = longint'(r) + f[best];
      if (dep < 0) dep = 0;
      if (dep > 64'sh0_FFFF_FFFF) dep = 64'sh0_FFFF_FFFF;
      e.depth = 32'(dep);
    end
    return e;
  endfunction

  // Input monitor: every accepted transaction queues its predicted record.
  // Values are read in the active region, so they are the pre-edge values.
  always @(posedge clk) begin
    pair_t p;
    if (!rst && in_valid && !in_stall) begin
      p = '{sphere_x, sphere_y, sphere_z, sphere_radius,
            box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z};
      contacts_due.push_back(predict_contact(p));
    end
  end

  // Output checker: each accepted result is compared with the oldest prediction.
  always @(posedge clk) begin
    contact_t e;
    if (!rst && out_valid && !out_stall) begin
      if (contacts_due.size() == 0) begin
        $error("result with no transaction outstanding");
        fail_count++;
      end else begin
        e = contacts_due.pop_front();
        if (contact !== e.contact) begin
          $error("contact expected %0d actual %0d", e.contact, contact);
          fail_count++;
        end
        if (normal_x !== e.nx) begin
          $error("normal_x expected %0d actual %0d", e.nx, normal_x);
          fail_count++;
        end
        if (normal_y !== e.ny) begin
          $error("normal_y expected %0d actual %0d", e.ny, normal_y);
          fail_count++;
        end
        if (normal_z !== e.nz) begin
          $error("normal_z expected %0d actual %0d", e.nz, normal_z);
          fail_count++;
        end
        if (depth !== e.depth) begin
          $error("depth expected %0d actual %0d", e.depth, depth);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b1;
    end else if (rx_hold_cycles > 0) begin
      rx_hold_cycles <= rx_hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Watchdog: a run with no transaction on either side for too long is hung.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one pair and returns once the block has taken it. A random gap
  // of idle cycles may come first; valid drops only when a gap is taken.
  task automatic send_pair(pair_t p);
    int gap;
    gap = 0;
    if ($urandom_range(99) < tx_idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sphere_x <= p.cx;
    sphere_y <= p.cy;
    sphere_z <= p.cz;
    sphere_radius <= p.radius;
    box_min_x <= p.lox;
    box_min_y <= p.loy;
    box_min_z <= p.loz;
    box_max_x <= p.hix;
    box_max_y <= p.hiy;
    box_max_z <= p.hiz;
    do @(posedge clk); while (in_stall);
  endtask

  // Lowers valid and waits until every predicted record has been checked.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (contacts_due.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
  endtask

  function automatic pair_t make_pair(int cx, int cy, int cz, bit [30:0] r,
                                      int lx, int ly, int lz, int hx, int hy, int hz);
    make_pair = '{cx, cy, cz, r, lx, ly, lz, hx, hy, hz};
  endfunction

  // A random pair. Most pairs sit close to a modest box so that contact,
  // the surface case and the face case all come up often; the rest are
  // full-range noise, flat boxes, inverted boxes and near-face centers.
  function automatic pair_t random_pair();
    pair_t p;
    int b[3], h[3], o[3], lo[3], hi[3], c[3], mode;
    bit [30:0] r;
    mode = $urandom_range(99);
    if (mode < 15) begin
      p = make_pair($urandom, $urandom, $urandom, 31'($urandom),
                    $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      return p;
    end
    r = 31'($urandom_range(0, 1 << 19));
    for (int k = 0; k < 3; k++) begin
      b[k] = int'($urandom_range(0, 1 << 22)) - (1 << 21);
      h[k] = $urandom_range(0, 1 << 18);
      if (mode < 22) h[k] = 0;
      lo[k] = b[k] - h[k];
      hi[k] = b[k] + h[k];
      if (mode >= 22 && mode < 28) begin
        lo[k] = b[k] + h[k];
        hi[k] = b[k] - h[k];
      end
      if (mode >= 28 && mode < 45) begin
        // Center just off or on a face, inside the small-distance threshold.
        o[k] = (k == 0) ? h[k] + int'($urandom_range(0, 80)) - 40
                        : int'($urandom_range(0, 2 * h[k])) - h[k];
      end else begin
        o[k] = int'($urandom_range(0, 2 * (h[k] + r))) - h[k] - int'(r);
      end
      c[k] = b[k] + (($urandom_range(1)) ? o[k] : -o[k]);
    end
    return make_pair(c[0], c[1], c[2], r, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  // Directed pairs: extremes of every field, every face and tie order,
  // the surface case, the zero-radius and inverted-box cases.
  task automatic test_directed();
    int m, x;
    m = 32'sh8000_0000;
    x = 32'sh7FFF_FFFF;
    // Far apart across the whole range: saturated squared distance.
    send_pair(make_pair(x, x, x, 31'h7FFF_FFFF, m, m, m, m, m, m));
    send_pair(make_pair(m, m, m, 31'h7FFF_FFFF, x, x, x, x, x, x));
    // Whole-range box with the center on a corner; depth equals the radius.
    send_pair(make_pair(m, m, m, 31'h7FFF_FFFF, m, m, m, x, x, x));
    send_pair(make_pair(x, x, x, 31'h7FFF_FFFF, m, m, m, x, x, x));
    // Center at the middle of a cube: all six faces tie, -x wins.
    send_pair(make_pair(0, 0, 0, 31'h10000, -65536, -65536, -65536, 65536, 65536, 65536));
    // Each face strictly nearest in turn.
    send_pair(make_pair(-60000, 0, 0, 31'h100, -65536, -65536, -65536, 65536, 65536, 65536));
    send_pair(make_pair(60000, 0, 0, 31'h100, -65536, -65536, -65536, 65536, 65536, 65536));
    send_pair(make_pair(0, -60000, 0, 31'h100, -65536, -65536, -65536, 65536, 65536, 65536));
    send_pair(make_pair(0, 60000, 0, 31'h100, -65536, -65536, -65536, 65536, 65536, 65536));
    send_pair(make_pair(0, 0, -60000, 31'h100, -65536, -65536, -65536, 65536, 65536, 65536));
    send_pair(make_pair(0, 0, 60000, 31'h100, -65536, -65536, -65536, 65536, 65536, 65536));
    // Tie between +x and -y: +x comes first.
    send_pair(make_pair(60000, -60000, 0, 31'h0, -65536, -65536, -65536, 65536, 65536, 65536));
    // Zero radius touching a face exactly, and zero radius just outside.
    send_pair(make_pair(65536, 0, 0, 31'h0, -65536, -65536, -65536, 65536, 65536, 65536));
    send_pair(make_pair(65537, 0, 0, 31'h0, -65536, -65536, -65536, 65536, 65536, 65536));
    // Inside the threshold but outside the box: face case, negative face distance.
    send_pair(make_pair(65536 + 40, 0, 0, 31'h0_0080, -65536, -65536, -65536,
                        65536, 65536, 65536));
    // Surface case along an axis, along a diagonal and exactly touching.
    send_pair(make_pair(131072, 0, 0, 31'h20000, -65536, -65536, -65536, 65536, 65536, 65536));
    send_pair(make_pair(-100000, -100000, -100000, 31'h20000, -65536, -65536, -65536,
                        65536, 65536, 65536));
    send_pair(make_pair(0, 0, -196608, 31'h20000, -65536, -65536, -65536, 65536, 65536, 65536));
    // Just above the threshold.
    send_pair(make_pair(65536 + 66, 0, 0, 31'h100, -65536, -65536, -65536, 65536, 65536, 65536));
    // Inverted box on every axis, center between and outside the corners.
    send_pair(make_pair(0, 0, 0, 31'h30000, 65536, 65536, 65536, -65536, -65536, -65536));
    send_pair(make_pair(200000, 0, 0, 31'h30000, 65536, 65536, 65536, -65536, -65536, -65536));
    // Point box at the extremes of the range.
    send_pair(make_pair(m, x, 0, 31'h7FFF_FFFF, m, x, 0, m, x, 0));
    wait_drained();
  endtask

  task automatic test_random(int count);
    repeat (count) send_pair(random_pair());
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_full_rate();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(100);
    tx_idle_pct = 28;
    rx_idle_pct = 28;
  endtask

  // The receiver holds off long enough to fill the pipeline while the
  // sender keeps offering, so the input side must stall.
  task automatic test_backpressure();
    rx_hold_cycles = 3 * PIPE_DEPTH;
    test_random(120);
  endtask

  // The sender pauses until every result is back, then resumes.
  task automatic test_pause();
    test_random(40);
    wait_drained();
    test_random(40);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(100);
    test_full_rate();
    test_backpressure();
    test_pause();
    wait_drained();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
